// ----- hdl/sacvt_pkg.sv -----
// shared types and constants for the set-associative tag model with victim store
// no dependencies
package sacvt_pkg;

    localparam int ADDR_W   = 64;
    localparam int SETS     = 64;
    localparam int WAYS     = 4;
    localparam int VICTIMS  = 8;

    localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int VIC_W    = (VICTIMS > 1) ? $clog2(VICTIMS) : 1;
    localparam int TAG_W    = ADDR_W - SET_W;
    localparam int ROW_W    = WAYS * TAG_W;

    localparam int OFF_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;

    // replacement policy codes
    localparam logic POLICY_RR  = 1'b0;
    localparam logic POLICY_LRU = 1'b1;

    localparam logic [OFF_W-1:0] OFFSET_RESET = 4'd6;

    typedef logic [TAG_W-1:0] t_tag;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture address, launch row read
        logic commit;   // compare, update stores, emit result
    } t_cmd;

endpackage

// ----- hdl/set_assoc_cache_victim_tag_model.sv -----
// top level of the set-associative tag model with shared victim store
// depends on sacvt_pkg, sacvt_ctrl, sacvt_dp (which holds sacvt_ram)
//
// Each access is a load then a compare: start is taken while busy is low, the
// set row is read from the tag ram in that cycle, and in the next cycle
// (busy high) the four ways and the eight victim entries are compared in
// parallel and the row and victim store are written back. The next access
// can start only in the cycle after that, set by the single read-then-write
// pass through the row ram. o_hit is shown with o_done for exactly one cycle,
// the cycle after busy; the receiver cannot stall it, so it must take the
// word in that cycle. Configuration (policy at index 0, offset bits at
// index 1) is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// write it only while no access is in flight; the block does not enforce it.
// Tag entries come out of reset as zero, so a zero tag hits on a fresh set.
module set_assoc_cache_victim_tag_model import sacvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_hit,
    output logic                  o_done
);

    t_cmd cmd;

    // sequencer: idle -> compare -> idle
    sacvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // tag stores, compare and replacement
    sacvt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_addr     (i_addr),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_hit      (o_hit),
        .o_done     (o_done)
    );

    // an accepted word always moves into the compare cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted access did not enter compare");

    // a compare cycle is always followed by a result word with busy low
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("compare cycle did not produce a result");

    // no result without a compare cycle before it
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an access");

endmodule

// ----- hdl/sacvt_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module sacvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sacvt_ctrl.sv -----
// two-state access sequencer: load then compare/commit
// depends on sacvt_pkg
module sacvt_ctrl import sacvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_start ? ST_CMP : ST_IDLE;
            ST_CMP:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_cmd.load   = i_start && (r_state == ST_IDLE);
    assign o_cmd.commit = (r_state == ST_CMP);

endmodule

// ----- hdl/sacvt_dp.sv -----
// datapath: config registers, set tag ram, victim store, compare and replace
// depends on sacvt_pkg, sacvt_ram
module sacvt_dp import sacvt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [ADDR_W-1:0]     i_addr,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_hit,
    output logic                  o_done
);

    logic             r_policy;
    logic [OFF_W-1:0] r_offset;
    t_tag             r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_vld;
    logic [SETS-1:0]  r_row_vld;
    t_tag             r_victim [VICTIMS];
    logic [VIC_W-1:0] r_vptr, n_vptr;
    logic [WAY_W-1:0] r_rrcnt, n_rrcnt;
    logic             r_hit, r_done;

    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_in;
    logic [ROW_W-1:0]  row_raw, row_wdata;
    t_tag              row_old [WAYS];
    t_tag              row_new [WAYS];
    logic              way_hit, vic_hit;
    logic [WAY_W-1:0]  way_idx;
    logic [VIC_W-1:0]  vic_idx, vic_sel;
    t_tag              out_tag;

    // address split
    assign shifted = i_addr >> r_offset;
    assign set_in  = shifted[SET_W-1:0];

    sacvt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (r_set),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.load),
        .i_raddr (set_in),
        .o_rdata (row_raw)
    );

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            row_old[w] = r_vld ? row_raw[w*TAG_W +: TAG_W] : '0;
        end

        // first matching way
        way_hit = 1'b0;
        way_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_old[w] == r_tag) begin
                way_hit = 1'b1;
                way_idx = WAY_W'(w);
            end
        end

        // first matching victim entry
        vic_hit = 1'b0;
        vic_idx = '0;
        for (int v = VICTIMS - 1; v >= 0; v--) begin
            if (r_victim[v] == r_tag) begin
                vic_hit = 1'b1;
                vic_idx = VIC_W'(v);
            end
        end

        n_rrcnt = (r_rrcnt == WAY_W'(WAYS - 1)) ? '0 : r_rrcnt + 1'b1;
        n_vptr  = (r_vptr == VIC_W'(VICTIMS - 1)) ? '0 : r_vptr + 1'b1;
        vic_sel = vic_hit ? vic_idx : n_vptr;

        for (int w = 0; w < WAYS; w++) begin
            row_new[w] = row_old[w];
        end
        out_tag = '0;

        if (way_hit) begin
            if (r_policy == POLICY_LRU) begin
                for (int w = 1; w < WAYS; w++) begin
                    if (WAY_W'(w) <= way_idx) begin
                        row_new[w] = row_old[w-1];
                    end
                end
                row_new[0] = r_tag;
            end
        end else begin
            if (r_policy == POLICY_LRU) begin
                out_tag = row_old[WAYS-1];
                for (int w = 1; w < WAYS; w++) begin
                    row_new[w] = row_old[w-1];
                end
                row_new[0] = r_tag;
            end else begin
                out_tag          = row_old[r_rrcnt];
                row_new[r_rrcnt] = r_tag;
            end
        end

        for (int w = 0; w < WAYS; w++) begin
            row_wdata[w*TAG_W +: TAG_W] = row_new[w];
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_LRU;
            r_offset <= OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: r_policy <= i_cfg_data[0];
                CFG_OFFSET: r_offset <= i_cfg_data[OFF_W-1:0];
                default:    ;
            endcase
        end
    end

    // access capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tag <= shifted[ADDR_W-1:SET_W];
            r_set <= set_in;
            r_vld <= r_row_vld[set_in];
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_vptr    <= '0;
            r_rrcnt   <= '0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            for (int v = 0; v < VICTIMS; v++) begin
                r_victim[v] <= '0;
            end
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_hit            <= way_hit || vic_hit;
                r_row_vld[r_set] <= 1'b1;
                if (!way_hit) begin
                    r_victim[vic_sel] <= out_tag;
                    if (!vic_hit) begin
                        r_vptr <= n_vptr;
                    end
                    if (r_policy == POLICY_RR) begin
                        r_rrcnt <= n_rrcnt;
                    end
                end
            end
        end
    end

    assign o_hit  = r_hit;
    assign o_done = r_done;

endmodule

// ----- verif/set_assoc_cache_victim_tag_model_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for set_assoc_cache_victim_tag_model: tag lookups with victim store
// depends on sacvt_pkg and the rtl under hdl; holds its own tag-store predictor
module set_assoc_cache_victim_tag_model_tb;
    import sacvt_pkg::*;

    // floor log2 of the set count, the width of the set field in the address
    localparam int IDX_BITS = $clog2(SETS + 1) - 1;
    localparam logic [ADDR_W-1:0] IDX_MASK = (64'd1 << IDX_BITS) - 64'd1;
    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PER_PHASE = 220;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        bit                drain;   // wait for every outstanding word before issuing
    } t_access;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              hit;
    } t_hit_expect;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ADDR_W-1:0]     i_addr = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_hit;
    logic                  o_done;

    // predictor copy of the tag stores and the configuration
    t_tag        row_tags [SETS][WAYS];
    t_tag        vic_tags [VICTIMS];
    int unsigned vic_next;
    int unsigned rr_way;
    logic        pol;
    logic [3:0]  off;

    t_access     access_q[$];
    t_hit_expect hit_expect_q[$];

    int n_issued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_main_hits = 0;
    int n_victim_hits = 0;
    int n_misses = 0;
    int n_cfg_writes = 0;
    int n_phases = 0;
    int n_cycles = 0;

    set_assoc_cache_victim_tag_model dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_addr     (i_addr),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_hit      (o_hit),
        .o_done     (o_done)
    );

    always #2 i_clk = ~i_clk;

    // pick the way that leaves the set and put the new tag in its place;
    // lru takes the last way and shifts the row, otherwise the round-robin way
    function automatic t_tag evict_way(input int unsigned s, input t_tag tg);
        t_tag        leaving;
        int unsigned k;
        if (pol == POLICY_LRU) begin
            leaving = row_tags[s][WAYS-1];
            for (k = WAYS - 1; k > 0; k--)
                row_tags[s][k] = row_tags[s][k-1];
            row_tags[s][0] = tg;
        end else begin
            leaving = row_tags[s][rr_way];
            row_tags[s][rr_way] = tg;
            rr_way = (rr_way + 1) % WAYS;
        end
        return leaving;
    endfunction

    // one access against the predictor: returns the expected hit and updates the stores
    function automatic logic lookup_tag(input logic [ADDR_W-1:0] a);
        t_tag        tg;
        int unsigned s;
        int unsigned k;
        int unsigned j;
        tg = t_tag'(a >> (off + IDX_BITS));
        s = 32'((a >> off) & IDX_MASK);
        // the set's ways first, way 0 first; zero tags match untouched entries
        for (k = 0; k < WAYS; k++) begin
            if (row_tags[s][k] == tg) begin
                if (pol == POLICY_LRU) begin
                    for (j = k; j > 0; j--)
                        row_tags[s][j] = row_tags[s][j-1];
                    row_tags[s][0] = tg;
                end
                n_main_hits++;
                return 1'b1;
            end
        end
        // then the shared victim store: swap with the leaving way
        for (k = 0; k < VICTIMS; k++) begin
            if (vic_tags[k] == tg) begin
                vic_tags[k] = evict_way(s, tg);
                n_victim_hits++;
                return 1'b1;
            end
        end
        // miss: the pointer advances before the leaving tag is parked
        vic_next = (vic_next + 1) % VICTIMS;
        vic_tags[vic_next] = evict_way(s, tg);
        n_misses++;
        return 1'b0;
    endfunction

    // build an address from tag, set and low bits under the current offset
    function automatic logic [ADDR_W-1:0] place_addr(input logic [ADDR_W-1:0] tg,
                                                     input int unsigned s,
                                                     input logic [ADDR_W-1:0] low);
        logic [ADDR_W-1:0] low_mask;
        low_mask = (64'd1 << off) - 64'd1;
        return (tg << (off + IDX_BITS)) | (ADDR_W'(s) << off) | (low & low_mask);
    endfunction

    // mostly a small tag pool over a few hot sets so that ways and victims refill
    // and hit again; the rest is fully random addresses and wide tags
    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] tg;
        int unsigned       s;
        if ($urandom_range(99) < 8)
            return {$urandom, $urandom};
        s = ($urandom_range(3) == 0) ? $urandom_range(SETS - 1) : $urandom_range(3);
        tg = ADDR_W'($urandom_range(11));
        if ($urandom_range(6) == 0)
            tg = {$urandom, $urandom};
        return place_addr(tg, s, {$urandom, $urandom});
    endfunction

    task automatic push_access(input logic [ADDR_W-1:0] a, input bit drain);
        t_access it;
        it.addr = a;
        it.drain = drain;
        access_q.push_back(it);
    endtask

    // block is idle once nothing is queued, offered or owed
    task automatic wait_idle();
        while (access_q.size() != 0 || start || hit_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_POLICY: pol = data[0];
            CFG_OFFSET: off = data;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // reconfigure while idle, then queue one phase of random accesses
    task automatic run_phase(input logic p, input logic [3:0] o, input bit spare);
        int i;
        wait_idle();
        write_reg(CFG_POLICY, {3'($urandom_range(7)), p});
        write_reg(CFG_OFFSET, o);
        if (spare) begin
            write_reg(CFG_SPARE_A, 4'($urandom_range(15)));
            write_reg(CFG_SPARE_B, 4'($urandom_range(15)));
        end
        n_phases++;
        for (i = 0; i < RAND_PER_PHASE; i++)
            push_access(rand_addr(), (i == 40) || ($urandom_range(199) == 0));
    endtask

    // driver: offers one word at a time, holds it until taken
    always @(negedge i_clk) begin : driver
        logic              go;
        logic              hold;
        logic [ADDR_W-1:0] nxt_addr;
        t_access           it;
        go = start;
        nxt_addr = i_addr;
        if (!i_rst_n) begin
            go = 1'b0;
        end else begin
            // the word on the port was taken at the last rising edge
            if (start && n_accepted == n_issued)
                go = 1'b0;
            if (!go) begin
                // junk on the address while idle, it must not be latched
                nxt_addr = {$urandom, $urandom};
                if (access_q.size() != 0) begin
                    // random gaps, except for a long stretch running back to back
                    hold = (n_issued < 600 || n_issued >= 900) && ($urandom_range(99) < 21);
                    if (access_q[0].drain && hit_expect_q.size() != 0)
                        hold = 1'b1;
                    if (!hold) begin
                        it = access_q.pop_front();
                        go = 1'b1;
                        nxt_addr = it.addr;
                        n_issued++;
                    end
                end
            end
        end
        start <= go;
        i_addr <= nxt_addr;
    end

    // monitor: check results first, then predict for a word taken at this edge
    always @(posedge i_clk) begin : monitor
        t_hit_expect ex;
        if (i_rst_n) begin
            if (o_done) begin
                n_results++;
                if (hit_expect_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result word, expected none actual hit=%0b",
                             $time, o_hit);
                end else begin
                    ex = hit_expect_q.pop_front();
                    if (o_hit !== ex.hit) begin
                        n_errors++;
                        $display("%0t: hit mismatch for addr %h expected %0b actual %0b",
                                 $time, ex.addr, ex.hit, o_hit);
                    end
                end
            end
            if (start && !busy) begin
                ex.addr = i_addr;
                ex.hit = lookup_tag(i_addr);
                hit_expect_q.push_back(ex);
                n_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still owed", $time, hit_expect_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        foreach (row_tags[s, w]) row_tags[s][w] = '0;
        foreach (vic_tags[k]) vic_tags[k] = '0;
        vic_next = 0;
        rr_way = 0;
        pol = POLICY_LRU;
        off = OFFSET_RESET;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        n_phases++;

        // directed part under reset configuration (lru, 64-byte lines)
        push_access('0, 1'b0);                        // zero tag hits a fresh set
        push_access(64'h0000_0000_0000_003f, 1'b0);   // offset bits only
        push_access('1, 1'b0);                        // widest tag, last set
        push_access(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        push_access(64'h5555_5555_5555_5555, 1'b0);
        // fill set 1 past its ways so tag 1 spills into the victim store
        for (i = 1; i <= 5; i++)
            push_access(place_addr(ADDR_W'(i), 1, {$urandom, $urandom}), 1'b0);
        push_access(place_addr(64'd1, 1, '0), 1'b0);  // victim hit, swap back in
        push_access(place_addr(64'd3, 1, '0), 1'b0);  // main hit in the last way
        push_access(place_addr(64'd3, 1, '0), 1'b0);  // main hit at the front
        push_access(place_addr(64'd2, 1, '0), 1'b1);  // victim hit on the tag swapped out above
        // enough misses on set 2 to wrap the victim pointer
        for (i = 20; i < 29; i++)
            push_access(place_addr(ADDR_W'(i), 2, '0), 1'b0);
        push_access(place_addr(64'd5, 1, '1), 1'b0);

        // both policies at both ends of the offset range and in between
        run_phase(POLICY_RR,  4'd0,  1'b1);
        run_phase(POLICY_LRU, 4'd12, 1'b0);
        run_phase(POLICY_RR,  4'd15, 1'b0);
        run_phase(POLICY_LRU, 4'd0,  1'b0);
        run_phase(POLICY_RR,  4'd6,  1'b1);
        run_phase(POLICY_LRU, 4'd15, 1'b0);
        run_phase(POLICY_RR,  4'd12, 1'b0);
        run_phase(POLICY_LRU, 4'd3,  1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("covered %0d accesses in %0d config phases (%0d register writes)",
                 n_accepted, n_phases, n_cfg_writes);
        $display("  %0d set hits, %0d victim hits, %0d misses, %0d result words, %0d errors",
                 n_main_hits, n_victim_hits, n_misses, n_results, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
